// ----- src/jhds_pkg.sv -----
package jhds_pkg;

  localparam int POSITION_BITS_DEF = 32;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_SOF_LO = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI = 8'hC2;

  localparam logic [7:0] UNIT_INCH = 8'd1;
  localparam logic [7:0] UNIT_CM   = 8'd2;

  localparam logic [23:0] DPI_DEFAULT = 24'd30000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  components;
    logic [23:0] dpi_x_hundredths;
    logic [23:0] dpi_y_hundredths;
  } out_item_t;

  function automatic logic [23:0] to_hundredths(input logic [7:0] unit,
                                                input logic [15:0] density);
    logic [23:0] res;
    res = DPI_DEFAULT;
    if (unit == UNIT_INCH) begin
      res = 24'(density) * 24'd100;
    end else if (unit == UNIT_CM) begin
      res = 24'(density) * 24'd254;
    end
    return res;
  endfunction

endpackage

// ----- src/jpeg_header_dimension_scanner.sv -----
// channel  ports                          direction  item
// in       in_valid in_ready in_data      input      one file byte, last flag
// out      out_valid out_ready out_data   output     one result per file
//
// one byte per cycle while in_ready is high; when the last byte of a file
// is taken, its result is registered into the output register, or into the
// skid entry if the output register is still full; this two-entry output
// buffer lets bytes flow while a result waits; input stalls only when both entries are full
// rst_n synchronous, active low: scanner returns to the start of a file

module jpeg_header_dimension_scanner #(
  parameter int POSITION_BITS = jhds_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jhds_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jhds_pkg::out_item_t out_data
);
  import jhds_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    PH_START, PH_LEN_HI, PH_LEN_LO, PH_WAIT, PH_CODE, PH_FRAME, PH_DONE
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] marker_pos_r, marker_pos_nxt;
  logic [7:0]    len_hi_r, len_hi_nxt;
  logic [7:0]    unit_r, unit_nxt;
  logic [15:0]   dens_x_r, dens_x_nxt;
  logic [15:0]   dens_y_r, dens_y_nxt;
  logic [39:0]   frame_r, frame_nxt;
  logic [3:0]    frame_off_r, frame_off_nxt;
  logic          dens_ok_r, dens_ok_nxt;
  logic          found_r, found_nxt;

  logic          out_valid_r, skid_valid_r;
  out_item_t     out_data_r, skid_data_r;
  out_item_t     res;
  logic          in_fire, out_take, res_valid;
  logic [15:0]   seg_len;
  logic [PB:0]   reach;
  logic [7:0]    b;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_take  = out_valid_r && out_ready;
  assign res_valid = in_fire && in_data.last_byte;
  assign b         = in_data.data_byte;

  assign seg_len = {len_hi_r, b};
  assign reach   = {1'b0, pos_r} + (PB + 1)'(seg_len) + (PB + 1)'(8);

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    marker_pos_nxt = marker_pos_r;
    len_hi_nxt     = len_hi_r;
    unit_nxt       = unit_r;
    dens_x_nxt     = dens_x_r;
    dens_y_nxt     = dens_y_r;
    frame_nxt      = frame_r;
    frame_off_nxt  = frame_off_r;
    dens_ok_nxt    = dens_ok_r;
    found_nxt      = found_r;

    if (pos_r == PB'(13)) begin
      unit_nxt = b;
    end else if (pos_r == PB'(14)) begin
      dens_x_nxt[15:8] = b;
    end else if (pos_r == PB'(15)) begin
      dens_x_nxt[7:0] = b;
    end else if (pos_r == PB'(16)) begin
      dens_y_nxt[15:8] = b;
    end else if (pos_r == PB'(17)) begin
      dens_y_nxt[7:0] = b;
      dens_ok_nxt     = 1'b1;
    end

    unique case (phase_r)
      PH_START: begin
        if (pos_r < PB'(3)) begin
          if (b != ((pos_r == PB'(1)) ? MARK_SOI : MARK_PREFIX)) phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = b;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < 16'd2 || reach > {1'b0, POS_MAX}) begin
          phase_nxt = PH_DONE;
        end else begin
          marker_pos_nxt = pos_r + PB'(seg_len) - PB'(1);
          phase_nxt      = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (pos_r == marker_pos_r) begin
          phase_nxt = (b == MARK_PREFIX) ? PH_CODE : PH_DONE;
        end
      end
      PH_CODE: begin
        if (b >= MARK_SOF_LO && b <= MARK_SOF_HI) begin
          frame_off_nxt = 4'd2;
          phase_nxt     = PH_FRAME;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_FRAME: begin
        if (frame_off_r >= 4'd5) frame_nxt = {frame_r[31:0], b};
        if (frame_off_r >= 4'd9) begin
          found_nxt = 1'b1;
          phase_nxt = PH_DONE;
        end
        frame_off_nxt = frame_off_r + 4'd1;
      end
      PH_DONE: begin
      end
      default: phase_nxt = PH_DONE;
    endcase

    if (pos_r != POS_MAX) pos_nxt = pos_r + PB'(1);
  end

  always_comb begin
    res = '0;
    if (found_nxt && dens_ok_nxt) begin
      res.found            = 1'b1;
      res.image_width      = frame_nxt[23:8];
      res.image_height     = frame_nxt[39:24];
      res.components       = frame_nxt[7:0];
      res.dpi_x_hundredths = to_hundredths(unit_nxt, dens_x_nxt);
      res.dpi_y_hundredths = to_hundredths(unit_nxt, dens_y_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r      <= PH_START;
      pos_r        <= '0;
      marker_pos_r <= '0;
      len_hi_r     <= '0;
      unit_r       <= '0;
      dens_x_r     <= '0;
      dens_y_r     <= '0;
      frame_r      <= '0;
      frame_off_r  <= '0;
      dens_ok_r    <= 1'b0;
      found_r      <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      marker_pos_r <= marker_pos_nxt;
      len_hi_r     <= len_hi_nxt;
      unit_r       <= unit_nxt;
      dens_x_r     <= dens_x_nxt;
      dens_y_r     <= dens_y_nxt;
      frame_r      <= frame_nxt;
      frame_off_r  <= frame_off_nxt;
      dens_ok_r    <= dens_ok_nxt;
      found_r      <= found_nxt;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == '0 && phase_r == PH_START && !found_r))
    else $error("scanner did not restart after last byte");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.image_width == 16'd0 && out_data_r.image_height == 16'd0 &&
       out_data_r.components == 8'd0 && out_data_r.dpi_x_hundredths == 24'd0 &&
       out_data_r.dpi_y_hundredths == 24'd0))
    else $error("fields nonzero in a not-found result");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && in_fire && !in_data.last_byte) |=> phase_r == PH_DONE)
    else $error("walk left done phase inside a file");

  a_found_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> phase_r == PH_DONE)
    else $error("frame found while walk still running");

endmodule

// ----- dv/tb_jpeg_header_dimension_scanner.sv -----
`timescale 1ns / 100ps

module tb_jpeg_header_dimension_scanner;
  import jhds_pkg::*;

  localparam int TARGET_BYTES = 1550;
  localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS_DEF) - 64'd1;

  typedef enum logic [3:0] {
    WALK_START,
    WALK_LEN_HI,
    WALK_LEN_LO,
    WALK_WAIT,
    WALK_CODE,
    WALK_FRAME,
    WALK_DONE
  } walk_t;

  class frame_size_tracker;
    out_item_t   expected_q[$];
    logic [31:0] position;
    logic [31:0] marker_at;
    logic [31:0] frame_origin;
    walk_t       phase;
    logic [7:0]  len_hi;
    logic [7:0]  density_unit;
    logic [15:0] dens_x;
    logic [15:0] dens_y;
    logic [39:0] frame_bytes;
    bit          density_seen;
    bit          frame_seen;
    int          errors;
    int          results;
    int          frames_found;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      position     = '0;
      marker_at    = '0;
      frame_origin = '0;
      phase        = WALK_START;
      len_hi       = '0;
      density_unit = '0;
      dens_x       = '0;
      dens_y       = '0;
      frame_bytes  = '0;
      density_seen = 1'b0;
      frame_seen   = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [23:0] scale_density(logic [15:0] dens);
      if (density_unit == UNIT_INCH) return {8'd0, dens} * 24'd100;
      if (density_unit == UNIT_CM) return {8'd0, dens} * 24'd254;
      return DPI_DEFAULT;
    endfunction

    function void abort_walk();
      phase = WALK_DONE;
    endfunction

    function void take_byte(in_item_t item);
      logic [7:0]  b;
      logic [63:0] here;
      logic [63:0] seg_len;
      logic [63:0] nxt;
      logic [63:0] off;
      out_item_t   res;
      b = item.data_byte;
      here = {32'd0, position};

      case (here)
        64'd13: density_unit = b;
        64'd14: dens_x[15:8] = b;
        64'd15: dens_x[7:0] = b;
        64'd16: dens_y[15:8] = b;
        64'd17: begin
          dens_y[7:0] = b;
          density_seen = 1'b1;
        end
        default: ;
      endcase

      case (phase)
        WALK_START: begin
          if (here < 64'd3) begin
            if (b != ((here == 64'd1) ? MARK_SOI : MARK_PREFIX)) abort_walk();
          end else begin
            phase = WALK_LEN_HI;
          end
        end
        WALK_LEN_HI: begin
          len_hi = b;
          phase = WALK_LEN_LO;
        end
        WALK_LEN_LO: begin
          seg_len = {48'd0, len_hi, b};
          nxt = here - 64'd1 + seg_len;
          if (seg_len < 64'd2 || nxt + 64'd9 > POS_LIMIT) begin
            abort_walk();
          end else begin
            marker_at = nxt[31:0];
            phase = WALK_WAIT;
          end
        end
        WALK_WAIT: begin
          if (position == marker_at) begin
            if (b != MARK_PREFIX) abort_walk();
            else phase = WALK_CODE;
          end
        end
        WALK_CODE: begin
          if (b >= MARK_SOF_LO && b <= MARK_SOF_HI) begin
            frame_origin = position - 32'd1;
            phase = WALK_FRAME;
          end else begin
            phase = WALK_LEN_HI;
          end
        end
        WALK_FRAME: begin
          off = {32'd0, position - frame_origin};
          if (off >= 64'd5) frame_bytes = {frame_bytes[31:0], b};
          if (off >= 64'd9) begin
            frame_seen = 1'b1;
            phase = WALK_DONE;
          end
        end
        default: ;
      endcase

      if (position != '1) position = position + 32'd1;

      if (item.last_byte) begin
        res = '0;
        if (frame_seen && density_seen) begin
          res.found            = 1'b1;
          res.image_height     = frame_bytes[39:24];
          res.image_width      = frame_bytes[23:8];
          res.components       = frame_bytes[7:0];
          res.dpi_x_hundredths = scale_density(dens_x);
          res.dpi_y_hundredths = scale_density(dens_y);
        end
        expected_q.push_back(res);
        clear_state();
      end
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        complain($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (want.found) frames_found++;
      if (got.found !== want.found || got.image_width !== want.image_width ||
          got.image_height !== want.image_height || got.components !== want.components ||
          got.dpi_x_hundredths !== want.dpi_x_hundredths ||
          got.dpi_y_hundredths !== want.dpi_y_hundredths) begin
        complain($sformatf(
          "result %0d: expected found=%0b w=%0d h=%0d c=%0d dx=%0d dy=%0d, got found=%0b w=%0d h=%0d c=%0d dx=%0d dy=%0d",
          results, want.found, want.image_width, want.image_height, want.components,
          want.dpi_x_hundredths, want.dpi_y_hundredths, got.found, got.image_width,
          got.image_height, got.components, got.dpi_x_hundredths, got.dpi_y_hundredths));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  frame_size_tracker tracker = new();
  logic [7:0] file_bytes[$];
  bit calm;
  int sink_hold;
  int bytes_sent;
  int files_sent;

  jpeg_header_dimension_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [15:0] pick_value(input logic [15:0] top);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return top;
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.take_byte(in_data);
    if (rst_n && out_valid && out_ready) tracker.match_result(out_data);
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) sink_hold = draw_wait();
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int hold;
    in_item_t item;
    hold = draw_wait();
    item.data_byte = b;
    item.last_byte = last;
    if (hold > 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    file_bytes.delete();
    files_sent++;
    if ($urandom_range(0, 3) == 0) calm = !calm;
  endtask

  task automatic build_random_file();
    int app_len;
    int seg_len;
    int frame_at;
    int cut;
    int k;
    logic [7:0] code;
    logic [7:0] den_unit;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] height;
    logic [15:0] width;
    case ($urandom_range(0, 3))
      0: den_unit = UNIT_INCH;
      1: den_unit = UNIT_CM;
      2: den_unit = 8'd0;
      default: den_unit = 8'($urandom);
    endcase
    dx = pick_value(16'hFFFF);
    dy = pick_value(16'hFFFF);
    app_len = ($urandom_range(0, 9) < 6) ? 16 : $urandom_range(2, 20);

    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(MARK_SOI);
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hE0);
    file_bytes.push_back(8'(app_len >> 8));
    file_bytes.push_back(8'(app_len));
    for (int p = 6; p < 4 + app_len; p++) begin
      case (p)
        13: file_bytes.push_back(den_unit);
        14: file_bytes.push_back(dx[15:8]);
        15: file_bytes.push_back(dx[7:0]);
        16: file_bytes.push_back(dy[15:8]);
        17: file_bytes.push_back(dy[7:0]);
        default: file_bytes.push_back(8'($urandom));
      endcase
    end

    // segments that the walk has to skip
    repeat ($urandom_range(0, 2)) begin
      do code = 8'($urandom); while (code >= MARK_SOF_LO && code <= MARK_SOF_HI);
      seg_len = $urandom_range(2, 10);
      file_bytes.push_back(MARK_PREFIX);
      file_bytes.push_back(code);
      file_bytes.push_back(8'(seg_len >> 8));
      file_bytes.push_back(8'(seg_len));
      repeat (seg_len - 2) file_bytes.push_back(8'($urandom));
    end

    frame_at = file_bytes.size();
    height = pick_value(16'hFFFF);
    width = pick_value(16'hFFFF);
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(MARK_SOF_LO + 8'($urandom_range(0, 2)));
    file_bytes.push_back(8'($urandom));
    file_bytes.push_back(8'($urandom));
    file_bytes.push_back(8'h08);
    file_bytes.push_back(height[15:8]);
    file_bytes.push_back(height[7:0]);
    file_bytes.push_back(width[15:8]);
    file_bytes.push_back(width[7:0]);
    file_bytes.push_back(8'(pick_value(16'd255)));
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));

    // broken files
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: begin
          cut = $urandom_range(1, file_bytes.size());
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        1: begin
          k = $urandom_range(0, file_bytes.size() - 1);
          file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
        end
        2: file_bytes[frame_at] = file_bytes[frame_at] ^ 8'($urandom_range(1, 255));
        3: begin
          file_bytes[4] = 8'd0;
          file_bytes[5] = 8'($urandom_range(0, 1));
        end
        default: begin
          file_bytes.delete();
          repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    calm = 1'b0;
    sink_hold = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // single byte file
    file_bytes = '{MARK_PREFIX};
    send_file();
    // bad start bytes
    file_bytes = '{MARK_PREFIX, 8'hD9};
    send_file();
    // segment length below two
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, 8'hE0, 8'h00, 8'h01};
    send_file();
    // frame right after a minimal segment, density bytes overlap the frame, height, components and densities maxed
    file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, 8'hE0, 8'h00, 8'h02,
                   MARK_PREFIX, MARK_SOF_LO + 8'd1, 8'h00, 8'h0B, 8'h08, 8'hFF, 8'hFF,
                   UNIT_CM, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();

    while (bytes_sent < TARGET_BYTES) begin
      build_random_file();
      send_file();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d files in %0d bytes, checked %0d results, %0d with a frame found",
             files_sent, bytes_sent, tracker.results, tracker.frames_found);
    $display("%0d mismatches, %0d results still expected", tracker.errors, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", tracker.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
src/jhds_pkg.sv
src/jpeg_header_dimension_scanner.sv
dv/tb_jpeg_header_dimension_scanner.sv
